FILE: src/assert_macros.svh
// Assertion helpers for the RTL files, used by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and synchronous reset.
`define SPQ_ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sorted priority queue check failed");

// Concurrent assertion on the block clock and reset.
`define SPQ_ASSERT(lbl, prop) \
   `SPQ_ASSERT_CLK(lbl, clock, reset, prop)

`endif

FILE: src/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   // Operation codes of a request
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Request transaction
   typedef struct packed {
      logic               cmd;
      logic signed [31:0] value;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic signed [31:0] head_value;
      logic               is_empty;
      logic [4:0]         entry_count;
      logic               overflow;
   } rsp_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_WRITE,
      S_POP_RD,
      S_POP_WR,
      S_DONE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_req;    // capture request, clear overflow
      logic set_ovf;     // push dropped
      logic pos_load;    // load insert position
      logic pos_one;     // insert position starts at 1 (else 0)
      logic pos_inc;     // advance scan
      logic scan_rd;     // read entry at scan position
      logic shift_init;  // shift index starts at occupancy
      logic shift_rd;    // read entry below shift index
      logic shift_wr;    // move read entry up one slot
      logic write_val;   // store new value, bump occupancy
      logic pop_init;    // pop index starts at head
      logic pop_rd;      // read entry above pop index
      logic pop_wr;      // move read entry down one slot
      logic occ_dec;     // pop finished
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_push;
      logic full;
      logic empty;
      logic val_ahead_head;
      logic pos_at_end;
      logic rd_ahead_val;
      logic shift_done;
      logic pop_done;
   } ctl_sts_type;

   // a ranks strictly ahead of b under the selected order
   function automatic logic ranks_ahead(input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input logic               smallest_first);
      logic res;
      if (smallest_first) begin
         res = (a < b);
      end else begin
         res = (a > b);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: src/spq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spq_datapath #(
   parameter int DEPTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire spq_pkg::req_type     req_data,
   input  wire logic                 csr_we,
   input  wire logic                 csr_wdata,
   input  wire spq_pkg::ctl_cmd_type cmd,
   output spq_pkg::ctl_sts_type      sts,
   output spq_pkg::rsp_type          rsp_data
);
   import spq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Entry storage, head at address 0
   logic signed [31:0] mem_ff [DEPTH];
   logic signed [31:0] rd_ff;

   req_type            req_ff,  req_in;
   logic [CW-1:0]      occ_ff,  occ_in;
   logic [AW-1:0]      pos_ff,  pos_in;
   logic [AW-1:0]      idx_ff,  idx_in;
   logic signed [31:0] head_ff, head_in;
   logic               ovf_ff,  ovf_in;
   logic               mode_ff, mode_in;

   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic [CW+4:0]      occ_wide;

   // Memory port selection
   always_comb begin
      rd_en   = cmd.scan_rd | cmd.shift_rd | cmd.pop_rd;
      rd_addr = pos_ff;
      if (cmd.shift_rd) begin
         rd_addr = idx_ff - AW'(1);
      end else if (cmd.pop_rd) begin
         rd_addr = idx_ff + AW'(1);
      end
      wr_en   = cmd.shift_wr | cmd.pop_wr | cmd.write_val;
      wr_addr = idx_ff;
      wr_data = rd_ff;
      if (cmd.write_val) begin
         wr_addr = pos_ff;
         wr_data = req_ff.value;
      end
   end

   // Memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   // Next values of the working registers
   always_comb begin
      req_in  = req_ff;
      occ_in  = occ_ff;
      pos_in  = pos_ff;
      idx_in  = idx_ff;
      head_in = head_ff;
      ovf_in  = ovf_ff;
      mode_in = csr_we ? csr_wdata : mode_ff;
      if (cmd.load_req) begin
         req_in = req_data;
         ovf_in = 1'b0;
      end
      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end
      if (cmd.pos_load) begin
         pos_in = cmd.pos_one ? AW'(1) : '0;
      end else if (cmd.pos_inc) begin
         pos_in = pos_ff + AW'(1);
      end
      if (cmd.shift_init) begin
         idx_in = occ_ff[AW-1:0];
      end else if (cmd.shift_wr) begin
         idx_in = idx_ff - AW'(1);
      end else if (cmd.pop_init) begin
         idx_in = '0;
      end else if (cmd.pop_wr) begin
         idx_in = idx_ff + AW'(1);
      end
      if (cmd.write_val) begin
         occ_in = occ_ff + CW'(1);
      end else if (cmd.occ_dec) begin
         occ_in = occ_ff - CW'(1);
      end
      // head copy follows every write to address 0
      if (wr_en && (wr_addr == '0)) begin
         head_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         ovf_ff  <= 1'b0;
         mode_ff <= 1'b0;
      end else begin
         occ_ff  <= occ_in;
         ovf_ff  <= ovf_in;
         mode_ff <= mode_in;
      end
      req_ff  <= req_in;
      pos_ff  <= pos_in;
      idx_ff  <= idx_in;
      head_ff <= head_in;
   end

   // Status to controller
   always_comb begin
      sts.is_push        = (req_ff.cmd == CMD_PUSH);
      sts.full           = (occ_ff == CW'(DEPTH));
      sts.empty          = (occ_ff == '0);
      sts.val_ahead_head = ranks_ahead(req_ff.value, head_ff, mode_ff);
      sts.pos_at_end     = (CW'(pos_ff) == occ_ff);
      sts.rd_ahead_val   = ranks_ahead(rd_ff, req_ff.value, mode_ff);
      sts.shift_done     = (idx_ff == pos_ff);
      sts.pop_done       = ((CW'(idx_ff) + CW'(1)) >= occ_ff);
   end

   // Result fields
   always_comb begin
      occ_wide             = (CW + 5)'(occ_ff);
      rsp_data.head_value  = (occ_ff == '0) ? '0 : head_ff;
      rsp_data.is_empty    = (occ_ff == '0);
      rsp_data.entry_count = occ_wide[4:0];
      rsp_data.overflow    = ovf_ff;
   end

   `SPQ_ASSERT(a_occ_bound, occ_ff <= CW'(DEPTH))
   `SPQ_ASSERT(a_ovf_full, ovf_ff |-> (occ_ff == CW'(DEPTH)))
   `SPQ_ASSERT(a_shift_above_pos, cmd.shift_wr |-> (idx_ff > pos_ff))

endmodule

`default_nettype wire

FILE: src/spq_controller.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire spq_pkg::ctl_sts_type sts,
   output spq_pkg::ctl_cmd_type      cmd,
   output logic                      busy,
   output logic                      rsp_valid
);
   import spq_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (sts.is_push) begin
               if (sts.full) begin
                  state_in = S_DONE;
               end else if (sts.empty || sts.val_ahead_head) begin
                  state_in = S_SHIFT_RD;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end else begin
               state_in = sts.empty ? S_DONE : S_POP_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = sts.pos_at_end ? S_SHIFT_RD : S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            state_in = sts.rd_ahead_val ? S_SCAN_RD : S_SHIFT_RD;
         end
         S_SHIFT_RD: begin
            state_in = sts.shift_done ? S_WRITE : S_SHIFT_WR;
         end
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_WRITE:    state_in = S_DONE;
         S_POP_RD: begin
            state_in = sts.pop_done ? S_DONE : S_POP_WR;
         end
         S_POP_WR:   state_in = S_POP_RD;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy         = 1'b0;
            cmd.load_req = start;
         end
         S_DECODE: begin
            if (sts.is_push) begin
               if (sts.full) begin
                  cmd.set_ovf = 1'b1;
               end else if (sts.empty || sts.val_ahead_head) begin
                  cmd.pos_load   = 1'b1;
                  cmd.shift_init = 1'b1;
               end else begin
                  cmd.pos_load = 1'b1;
                  cmd.pos_one  = 1'b1;
               end
            end else if (!sts.empty) begin
               cmd.pop_init = 1'b1;
            end
         end
         S_SCAN_RD: begin
            if (sts.pos_at_end) begin
               cmd.shift_init = 1'b1;
            end else begin
               cmd.scan_rd = 1'b1;
            end
         end
         S_SCAN_CMP: begin
            if (sts.rd_ahead_val) begin
               cmd.pos_inc = 1'b1;
            end else begin
               cmd.shift_init = 1'b1;
            end
         end
         S_SHIFT_RD: begin
            cmd.shift_rd = !sts.shift_done;
         end
         S_SHIFT_WR: cmd.shift_wr  = 1'b1;
         S_WRITE:    cmd.write_val = 1'b1;
         S_POP_RD: begin
            if (sts.pop_done) begin
               cmd.occ_dec = 1'b1;
            end else begin
               cmd.pop_rd = 1'b1;
            end
         end
         S_POP_WR:   cmd.pop_wr = 1'b1;
         S_DONE:     rsp_valid  = 1'b1;
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: src/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted priority queue of signed 32-bit values, DEPTH entries.
// Request: drive req_data (cmd push/pop, value) and pulse start while
//   busy is low; the transaction is taken at that clock edge.
// Result: rsp_valid is high for exactly one cycle with rsp_data holding
//   the head value (0 when empty), empty flag, entry count (low 5 bits of
//   the occupancy) and overflow flag. The receiver cannot stall; the
//   result must be taken in that cycle.
// csr_we/csr_wdata write the order bit: 0 largest first, 1 smallest first.
//   Write it only while busy is low.
// Steps: a push into a full queue or a pop on an empty queue goes straight
//   to the result; a push scans for its slot, moves the entries from that
//   slot on up one slot and writes the value; a pop moves each later entry
//   down one slot. The queue returns to idle after each result.
// Cost is set by the single entry memory: one read, registered, then one
//   write per moved entry, and one read per scanned entry.
// Reset (synchronous, active high) empties the queue and clears the
//   order bit; stored entries are not cleared, no clearing pass is needed.

module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire spq_pkg::req_type req_data,
   output logic                  rsp_valid,
   output spq_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_wdata
);
   import spq_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // Sequencer
   spq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Entry memory and working registers
   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
